@@ hdl/seven_segment_text_formatter_macros.svh @@
// Assertion macros for the seven-segment text formatter
`ifndef SEVEN_SEGMENT_TEXT_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_FORMATTER_MACROS_SVH

`ifndef SYNTH
// check a condition at every rising clock edge outside reset
`define SSTF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sstf assertion failed");
// check a same-cycle implication outside reset
`define SSTF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sstf assertion failed");
`else
`define SSTF_ASSERT_ALWAYS(lbl, expr)
`define SSTF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

@@ hdl/sstf_pkg.sv @@
// Shared constants for the seven-segment text formatter
package sstf_pkg;

  localparam int GRID_COUNT = 6;
  localparam int CNT_W      = $clog2(GRID_COUNT + 1);
  localparam int GRID_IDX_W = 3;
  localparam int SEG_W      = 8;
  localparam int CHAR_W     = 8;

  localparam logic [SEG_W-1:0]  SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0]  DP_MASK   = 8'h80;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

endpackage

@@ hdl/seven_segment_text_formatter.sv @@
// Top level: text stream to seven-segment grid patterns
//
// Input channel (in_*): one ASCII character per transaction in in_tdata.
// in_tlast marks the end of the string; its tdata is ignored. A '.' after a
// character sets the decimal point of that character; stray dots are dropped.
// Output channel (out_*): one grid pattern per transaction, segments and
// grid index in out_tdata, out_tlast on the last grid of the frame.
// A dot's merged pattern is on the output register in the cycle after its
// transaction; a character's pattern is held until the next character, dot
// or end-of-string. Ordinary characters and dots are taken one per cycle
// while the receiver keeps up. An end-of-string on a frame that is not full
// holds in_tready low in the flush state while the held pattern and the
// blank padding for up to 6 grids drain through the output register.
// Reset (rst_n low, synchronous) empties the output register and clears the
// held pattern and grid count. When the receiver stalls, the output register
// holds its transaction and in_tready drops until it is taken.
`include "seven_segment_text_formatter_macros.svh"

module seven_segment_text_formatter
  import sstf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] segments, [10:8] grid_index, rest zero
  output logic        out_tlast   // last_grid
);

  logic                  out_valid_r, out_valid_nxt;
  logic [SEG_W-1:0]      out_seg_r, out_seg_nxt;
  logic [GRID_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [SEG_W-1:0]      pend_code_r, pend_code_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  flush_r, flush_nxt;

  logic             out_free;
  logic             in_fire;
  logic             emit;
  logic [SEG_W-1:0] emit_seg;
  logic [SEG_W-1:0] enc_seg;
  logic [CNT_W-1:0] count_inc;

  sstf_encoder u_enc (
    .char_code (in_tdata),
    .segments  (enc_seg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !flush_r && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    pend_code_nxt  = pend_code_r;
    pend_valid_nxt = pend_valid_r;
    count_nxt      = count_r;
    flush_nxt      = flush_r;
    emit           = 1'b0;
    emit_seg       = SEG_BLANK;

    if (flush_r) begin
      // drain held pattern first, then blanks
      if (out_free) begin
        emit           = 1'b1;
        emit_seg       = pend_valid_r ? pend_code_r : SEG_BLANK;
        pend_valid_nxt = 1'b0;
        pend_code_nxt  = SEG_BLANK;
        if (count_inc == CNT_W'(GRID_COUNT)) begin
          flush_nxt = 1'b0;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
    end else if (in_fire) begin
      if (in_tlast) begin
        if (count_r < CNT_W'(GRID_COUNT)) begin
          flush_nxt = 1'b1;
        end else begin
          pend_valid_nxt = 1'b0;
          pend_code_nxt  = SEG_BLANK;
          count_nxt      = '0;
        end
      end else if (in_tdata == CHAR_DOT) begin
        if (pend_valid_r) begin
          emit           = 1'b1;
          emit_seg       = pend_code_r | DP_MASK;
          count_nxt      = count_inc;
          pend_valid_nxt = 1'b0;
          pend_code_nxt  = SEG_BLANK;
        end
      end else begin
        if (pend_valid_r) begin
          emit      = 1'b1;
          emit_seg  = pend_code_r;
          count_nxt = count_inc;
        end
        if (count_nxt < CNT_W'(GRID_COUNT)) begin
          pend_code_nxt  = enc_seg;
          pend_valid_nxt = 1'b1;
        end else begin
          pend_code_nxt  = SEG_BLANK;
          pend_valid_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_seg_nxt   = out_seg_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = emit_seg;
      out_idx_nxt   = GRID_IDX_W'(count_r);
      out_last_nxt  = (count_r == CNT_W'(GRID_COUNT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_code_r  <= SEG_BLANK;
      pend_valid_r <= 1'b0;
      count_r      <= '0;
      flush_r      <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_code_r  <= pend_code_nxt;
      pend_valid_r <= pend_valid_nxt;
      count_r      <= count_nxt;
      flush_r      <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r  <= out_seg_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_idx_r, out_seg_r};
  assign out_tlast  = out_last_r;

  `SSTF_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(GRID_COUNT))
  `SSTF_ASSERT_IMPL(a_pend_has_room, pend_valid_r, count_r < CNT_W'(GRID_COUNT))
  `SSTF_ASSERT_IMPL(a_flush_has_room, flush_r, count_r < CNT_W'(GRID_COUNT))
  `SSTF_ASSERT_IMPL(a_flush_blocks_input, flush_r, !in_tready)

endmodule

@@ hdl/sstf_encoder.sv @@
// ASCII to seven-segment pattern lookup with case folding
module sstf_encoder
  import sstf_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output logic [SEG_W-1:0]  segments
);

  logic [CHAR_W-1:0] upper;

  // fold a..z onto A..Z
  assign upper = (char_code >= 8'h61 && char_code <= 8'h7A) ?
                 (char_code - 8'h20) : char_code;

  always_comb begin
    case (upper)
      8'h30: segments = 8'h3F;
      8'h31: segments = 8'h06;
      8'h32: segments = 8'h5B;
      8'h33: segments = 8'h4F;
      8'h34: segments = 8'h66;
      8'h35: segments = 8'h6D;
      8'h36: segments = 8'h7D;
      8'h37: segments = 8'h07;
      8'h38: segments = 8'h7F;
      8'h39: segments = 8'h6F;
      8'h41: segments = 8'h77;
      8'h42: segments = 8'h7C;
      8'h43: segments = 8'h39;
      8'h44: segments = 8'h5E;
      8'h45: segments = 8'h79;
      8'h46: segments = 8'h71;
      8'h47: segments = 8'h3D;
      8'h48: segments = 8'h76;
      8'h49: segments = 8'h06;
      8'h4A: segments = 8'h1E;
      8'h4B: segments = 8'h76;
      8'h4C: segments = 8'h38;
      8'h4D: segments = 8'h37;
      8'h4E: segments = 8'h54;
      8'h4F: segments = 8'h3F;
      8'h50: segments = 8'h73;
      8'h51: segments = 8'h67;
      8'h52: segments = 8'h50;
      8'h53: segments = 8'h6D;
      8'h54: segments = 8'h78;
      8'h55: segments = 8'h3E;
      8'h56: segments = 8'h3E;
      8'h57: segments = 8'h2A;
      8'h58: segments = 8'h76;
      8'h59: segments = 8'h6E;
      8'h5A: segments = 8'h5B;
      default: segments = SEG_BLANK;
    endcase
  end

endmodule

@@ verif/seven_segment_text_formatter_test.sv @@
// Self-checking testbench for the seven-segment text formatter stream block
`timescale 1ns / 1ps

module seven_segment_text_formatter_test
  import sstf_pkg::*;
();

  localparam int         QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int         ITEM_TARGET  = 500;
  localparam int         TAIL_CYCLES  = 12;    // end marker drains up to six grids
  localparam int         SCRIPT_LEN   = 25;
  localparam logic       CHR          = 1'b0;
  localparam logic       EOS          = 1'b1;
  localparam logic       PRED         = 1'b0;  // expectation from the predictor
  localparam logic       TYPED        = 1'b1;  // expectation written in the row

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] LETTER_GLYPH [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
    8'h76, 8'h38, 8'h37, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B
  };

  typedef struct packed {
    logic [7:0] seg;
    logic [2:0] idx;
    logic       last;
  } grid_pat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    logic [2:0] n;
    grid_pat_t  pat;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_code
  logic        in_tlast;   // end_of_string
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] segments, [10:8] grid_index, rest zero
  logic        out_tlast;  // last_grid

  seven_segment_text_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // predictor state
  logic [7:0]  held_seg;
  logic        held_ok;
  int          grids_out;

  grid_pat_t   due_grids [$];
  grid_pat_t   fresh [$];
  grid_pat_t   got_pat;
  grid_pat_t   want_pat;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  int          mismatches;
  int          items_sent;
  int          strings_closed;
  int          grids_checked;

  stim_row_t script [SCRIPT_LEN] = '{
    '{8'h00,    EOS, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},  // end marker straight after reset
    '{CHAR_DOT, CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},  // stray dot
    '{"0",      CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},
    '{CHAR_DOT, CHR, TYPED, 3'd1, '{8'hBF, 3'd0, 1'b0}},  // dot merged
    '{"z",      CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},
    '{"a",      CHR, TYPED, 3'd1, '{8'h5B, 3'd1, 1'b0}},
    '{"9",      CHR, TYPED, 3'd1, '{8'h77, 3'd2, 1'b0}},
    '{8'hFF,    CHR, TYPED, 3'd1, '{8'h6F, 3'd3, 1'b0}},  // non-ASCII gives blank
    '{CHAR_DOT, CHR, TYPED, 3'd1, '{8'h80, 3'd4, 1'b0}},  // dot on a blank
    '{"Z",      CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},
    '{CHAR_DOT, CHR, TYPED, 3'd1, '{8'hDB, 3'd5, 1'b1}},
    '{"M",      CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},  // frame full, dropped
    '{CHAR_DOT, CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},
    '{8'hFF,    EOS, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},  // end marker on full frame
    '{"A",      CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},
    '{CHAR_DOT, CHR, TYPED, 3'd1, '{8'hF7, 3'd0, 1'b0}},
    '{CHAR_DOT, CHR, TYPED, 3'd0, '{8'h00, 3'd0, 1'b0}},  // second dot is stray
    '{8'h00,    CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{"/",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{":",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{CHAR_DOT, EOS, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},  // data ignored under tlast
    '{"@",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{"[",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{"{",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}},
    '{"7",      CHR, PRED,  3'd0, '{8'h00, 3'd0, 1'b0}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] glyph_of(logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch >= "a" && ch <= "z") up = ch - 8'h20;
    if (ch >= "0" && ch <= "9") return DIGIT_GLYPH[ch - "0"];
    if (up >= "A" && up <= "Z") return LETTER_GLYPH[up - "A"];
    return SEG_BLANK;
  endfunction

  function automatic void put_grid(logic [7:0] seg, ref grid_pat_t pats[$]);
    pats.push_back('{seg, grids_out[2:0], grids_out == GRID_COUNT - 1});
    grids_out++;
  endfunction

  function automatic void render_char(logic [7:0] ch, logic eos, ref grid_pat_t pats[$]);
    if (eos) begin
      if (held_ok && grids_out < GRID_COUNT) put_grid(held_seg, pats);
      while (grids_out < GRID_COUNT) put_grid(SEG_BLANK, pats);
      held_seg  = '0;
      held_ok   = 1'b0;
      grids_out = 0;
    end else if (ch == CHAR_DOT) begin
      if (held_ok) begin
        put_grid(held_seg | DP_MASK, pats);
        held_ok  = 1'b0;
        held_seg = '0;
      end
    end else begin
      if (held_ok) begin
        put_grid(held_seg, pats);
        held_ok  = 1'b0;
        held_seg = '0;
      end
      if (grids_out < GRID_COUNT) begin
        held_seg = glyph_of(ch);
        held_ok  = 1'b1;
      end
    end
  endfunction

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 28) return 8'("0") + 8'($urandom_range(9));
    if (pick < 50) return 8'("A") + 8'($urandom_range(25));
    if (pick < 66) return 8'("a") + 8'($urandom_range(25));
    if (pick < 84) return CHAR_DOT;
    return 8'($urandom_range(255));
  endfunction

  // one transaction on the input side, with random gaps ahead of it
  task automatic send_item(logic [7:0] ch, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eos;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
    if (eos) strings_closed++;
  endtask

  task automatic send_predicted(logic [7:0] ch, logic eos);
    send_item(ch, eos);
    fresh.delete();
    render_char(ch, eos, fresh);
    foreach (fresh[i]) due_grids.push_back(fresh[i]);
  endtask

  // hold the input quiet until every predicted grid has come out
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_grids.size() != 0);
  endtask

  task automatic report_mismatch(string what, grid_pat_t want, logic [15:0] data, logic last);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: want seg=%02h idx=%0d last=%0b, got tdata=%04h tlast=%0b",
               what, want.seg, want.idx, want.last, data, last);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_pat = '{out_tdata[7:0], out_tdata[10:8], out_tlast};
      grids_checked++;
      if (due_grids.size() == 0) begin
        report_mismatch("unexpected grid", '0, out_tdata, out_tlast);
      end else begin
        want_pat = due_grids.pop_front();
        if (got_pat !== want_pat || out_tdata[15:11] !== 5'd0)
          report_mismatch("grid", want_pat, out_tdata, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("seven_segment_text_formatter_test: done, errors");
      $finish;
    end
  end

  initial begin
    int len;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    held_seg       = '0;
    held_ok        = 1'b0;
    grids_out      = 0;
    quiet_cycles   = 0;
    mismatches     = 0;
    items_sent     = 0;
    strings_closed = 0;
    grids_checked  = 0;
    send_idle_pct  = 12;
    recv_idle_pct  = 50;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      send_item(script[r].ch, script[r].eos);
      fresh.delete();
      render_char(script[r].ch, script[r].eos, fresh);
      if (script[r].typed) begin
        if (script[r].n != 0) due_grids.push_back(script[r].pat);
      end else begin
        foreach (fresh[i]) due_grids.push_back(fresh[i]);
      end
    end
    drain_outputs();

    // sender-light/receiver-heavy, then reversed, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 12 : 0;
      while (items_sent < SCRIPT_LEN + (phase + 1) * ITEM_TARGET / 3) begin
        if ($urandom_range(19) == 0) drain_outputs();
        len = $urandom_range(9);
        for (int k = 0; k < len; k++) send_predicted(random_char(), 1'b0);
        // an unterminated string runs on into the next one
        if ($urandom_range(9) != 0) send_predicted(8'($urandom_range(255)), 1'b1);
      end
      drain_outputs();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_grids.size() != 0) begin
      mismatches++;
      $display("%0d grid patterns never arrived", due_grids.size());
    end

    $display("covered %0d characters and end markers (%0d strings closed) under three",
             items_sent, strings_closed);
    $display("idle patterns; %0d grid patterns checked, %0d mismatches",
             grids_checked, mismatches);
    if (mismatches == 0)
      $display("seven_segment_text_formatter_test: done, clean");
    else
      $display("seven_segment_text_formatter_test: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sstf_pkg.sv
hdl/sstf_encoder.sv
hdl/seven_segment_text_formatter.sv
verif/seven_segment_text_formatter_test.sv
